[hdl/kmd_pkg.sv]
// Shared types, constants and register codes of the keypad debounce and long-press block.
package kmd_pkg;

	localparam int COLUMNS_DEF = 4;
	localparam int ROWS_DEF    = 5;

	localparam int COL_W     = 2;
	localparam int ROW_W     = 3;
	localparam int ELAPSED_W = 16;
	localparam int DUR_W     = 32;
	localparam int TIME_W    = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam int EVQ_DEPTH = 4;

	localparam logic [TIME_W-1:0] DEBOUNCE_RST     = 16'd20;
	localparam logic [TIME_W-1:0] LONG_PRESS_RST   = 16'd1000;
	localparam logic              ACTIVE_LEVEL_RST = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL = 2'd2;

	typedef enum logic [1:0] {
		EV_PRESSED  = 2'd0,
		EV_LONG     = 2'd1,
		EV_RELEASED = 2'd2
	} kmd_ev_code_t;

	typedef struct packed {
		kmd_ev_code_t     code;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic [DUR_W-1:0] duration;
		logic             last;
	} kmd_event_t;

	// Up to two events per sampled key; v1 is only set together with v0.
	typedef struct packed {
		logic       v0;
		logic       v1;
		kmd_event_t e0;
		kmd_event_t e1;
	} kmd_evpair_t;

	typedef struct packed {
		logic [TIME_W-1:0] debounce;
		logic [TIME_W-1:0] long_press;
		logic              active_level;
	} kmd_cfg_t;

endpackage

[hdl/kmd_keys.sv]
// Per-key duration and long-press state with the event decision for one sampled key.
module kmd_keys import kmd_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 commit,
	input  logic [COL_W-1:0]     column,
	input  logic [ROW_W-1:0]     key_row,
	input  logic                 pin_level,
	input  logic [ELAPSED_W-1:0] elapsed_ms,
	input  kmd_cfg_t             cfg,
	output kmd_evpair_t          events
);

	localparam int KEYS   = COLUMNS * ROWS;
	localparam int IDX_W  = (KEYS > 1) ? $clog2(KEYS) : 1;
	localparam int CALC_W = COL_W + ROW_W + 1;
	localparam logic [COL_W+1:0] COL_LIM = (COL_W+2)'(COLUMNS);
	localparam logic [ROW_W:0] ROW_LIM = (ROW_W+1)'(ROWS);

	logic [DUR_W-1:0]  dur_q [KEYS];
	logic [KEYS-1:0]   long_q;

	logic              timing_ok;
	logic              in_range;
	logic              ok;
	logic [CALC_W-1:0] idx_full;
	logic [IDX_W-1:0]  idx;
	logic [DUR_W-1:0]  prev;
	logic [DUR_W:0]    sum;
	logic [DUR_W-1:0]  dur;
	logic [DUR_W-1:0]  deb_w;
	logic [DUR_W-1:0]  long_w;
	logic              active;
	logic              press;
	logic              lng;
	logic              rel;

	always_comb begin
		timing_ok = (cfg.debounce != '0) && (cfg.long_press >= cfg.debounce);
		in_range  = ({2'b00, column} < COL_LIM) && ({1'b0, key_row} < ROW_LIM);
		ok        = timing_ok && in_range;
		idx_full  = CALC_W'(column) * CALC_W'(ROWS) + CALC_W'(key_row);
		idx       = in_range ? idx_full[IDX_W-1:0] : '0;
		prev      = dur_q[idx];
		sum       = {1'b0, prev} + (DUR_W+1)'(elapsed_ms);
		dur       = sum[DUR_W] ? '1 : sum[DUR_W-1:0];
		deb_w     = DUR_W'(cfg.debounce);
		long_w    = DUR_W'(cfg.long_press);
		active    = (pin_level == cfg.active_level);
		press     = ok && active && (prev < deb_w) && (dur >= deb_w);
		lng       = ok && active && (dur >= long_w) && !long_q[idx];
		rel       = ok && !active && (prev >= deb_w);
	end

	always_comb begin
		events.v0 = press || lng || rel;
		events.v1 = press && lng;

		events.e0.column   = column;
		events.e0.row      = key_row;
		events.e0.duration = active ? dur : prev;
		events.e0.last     = !(press && lng);
		priority if (press) begin
			events.e0.code = EV_PRESSED;
		end else if (lng) begin
			events.e0.code = EV_LONG;
		end else begin
			events.e0.code = EV_RELEASED;
		end

		events.e1.code     = EV_LONG;
		events.e1.column   = column;
		events.e1.row      = key_row;
		events.e1.duration = dur;
		events.e1.last     = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEYS; i++) begin
				dur_q[i] <= '0;
			end
			long_q <= '0;
		end else if (commit && ok) begin
			if (active) begin
				dur_q[idx] <= dur;
				if (lng) begin
					long_q[idx] <= 1'b1;
				end
			end else begin
				dur_q[idx]  <= '0;
				long_q[idx] <= 1'b0;
			end
		end
	end

endmodule

[hdl/kmd_evq.sv]
// Small event queue that takes up to two events per cycle and hands out one.
module kmd_evq import kmd_pkg::*; #(
	parameter int DEPTH = EVQ_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  kmd_evpair_t events,
	output logic        room2,
	output logic        head_valid,
	input  logic        pop,
	output kmd_event_t  head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	kmd_event_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             push0;
	logic             push1;
	logic             do_pop;
	logic [PTR_W:0]   n_push;

	always_comb begin
		push0      = push && events.v0;
		push1      = push && events.v1;
		n_push     = (PTR_W+1)'(push0) + (PTR_W+1)'(push1);
		head_valid = (count_q != '0);
		do_pop     = pop && head_valid;
		room2      = (count_q <= (PTR_W+1)'(DEPTH - 2));
		head       = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wr_ptr_q] <= events.e0;
		end
		if (push1) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= events.e1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[PTR_W-1:0];
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + n_push - (PTR_W+1)'(do_pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W+1)'(DEPTH))
		else $error("event queue count above depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		push1 |-> push0)
		else $error("second event pushed without a first");

	assert property (@(posedge clk) disable iff (!arst_n)
		push0 |-> room2)
		else $error("event pushed without room for two");

	assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !push0) |=> (count_q == $past(count_q) - (PTR_W+1)'(1)))
		else $error("event queue count wrong after a pop");

endmodule

[hdl/keypad_matrix_debounce_long_press.sv]
// Top level of the keypad matrix debounce and long-press detector.
// One sampled key is taken per cycle into an input register unless the input
// stalls; there it is checked against that key's stored duration and long-press
// flag, the state is written back and zero, one or two events (press, long
// press, release) enter a four-entry event queue, from whose head they are
// offered. Events leave one per cycle while out_ready is high, which sets the
// sustained rate: one item per cycle while items cause at most one event each,
// and an item that causes both press and long press adds a second event to the
// output. The input stalls only when the event queue has fewer than two free
// entries. Configuration is written through cfg_write/cfg_index/cfg_data and
// should only change while no items are in flight.
module keypad_matrix_debounce_long_press import kmd_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [COL_W-1:0]     column,
	input  logic [ROW_W-1:0]     key_row,
	input  logic                 pin_level,
	input  logic [ELAPSED_W-1:0] elapsed_ms,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           event_code,
	output logic [COL_W-1:0]     event_column,
	output logic [ROW_W-1:0]     event_row,
	output logic [DUR_W-1:0]     event_duration,
	output logic                 last_event
);

	kmd_cfg_t             cfg_q;
	logic                 valid_s1;
	logic [COL_W-1:0]     column_s1;
	logic [ROW_W-1:0]     row_s1;
	logic                 level_s1;
	logic [ELAPSED_W-1:0] elapsed_s1;
	logic                 in_fire;
	logic                 s1_fire;
	logic                 room2;
	kmd_evpair_t          events;
	kmd_event_t           head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce     <= DEBOUNCE_RST;
			cfg_q.long_press   <= LONG_PRESS_RST;
			cfg_q.active_level <= ACTIVE_LEVEL_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DEBOUNCE:     cfg_q.debounce     <= cfg_data[TIME_W-1:0];
				REG_LONG_PRESS:   cfg_q.long_press   <= cfg_data[TIME_W-1:0];
				REG_ACTIVE_LEVEL: cfg_q.active_level <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign s1_fire  = valid_s1 && room2;
	assign in_ready = !valid_s1 || room2;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			column_s1  <= column;
			row_s1     <= key_row;
			level_s1   <= pin_level;
			elapsed_s1 <= elapsed_ms;
		end
	end

	kmd_keys #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_keys (
		.clk        (clk),
		.arst_n     (arst_n),
		.commit     (s1_fire),
		.column     (column_s1),
		.key_row    (row_s1),
		.pin_level  (level_s1),
		.elapsed_ms (elapsed_s1),
		.cfg        (cfg_q),
		.events     (events)
	);

	kmd_evq #(
		.DEPTH (EVQ_DEPTH)
	) u_evq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (s1_fire),
		.events     (events),
		.room2      (room2),
		.head_valid (out_valid),
		.pop        (out_ready),
		.head       (head)
	);

	assign event_code     = head.code;
	assign event_column   = head.column;
	assign event_row      = head.row;
	assign event_duration = head.duration;
	assign last_event     = head.last;

endmodule
